>>> hdl/cva_pkg.sv
// ----------------------------------------------------------------------------
// Cost volume accumulate package
// Item types, field widths, register indexes and divider sizing shared by
// the cost volume accumulate modules.
// ----------------------------------------------------------------------------
package cva_pkg;

   localparam int CH_W       = 16;
   localparam int COST_W     = 48;
   localparam int HIT_W      = 16;
   localparam int DIVD_W     = COST_W + HIT_W;
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = COST_W / DIV_BITS;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [HIT_W-1:0]  HIT_MAX  = '1;
   localparam logic [COST_W-1:0] COST_MAX = '1;

   localparam logic REG_NORM_MODE      = 1'b0;
   localparam logic REG_SINGLE_CHANNEL = 1'b1;

   typedef struct packed {
      logic [9:0]      pixel_index;
      logic [4:0]      layer;
      logic            valid_req;
      logic [CH_W-1:0] warped_c0;
      logic [CH_W-1:0] warped_c1;
      logic [CH_W-1:0] warped_c2;
      logic [CH_W-1:0] ref_c0;
      logic [CH_W-1:0] ref_c1;
      logic [CH_W-1:0] ref_c2;
   } req_item_type;

   typedef struct packed {
      logic [COST_W-1:0] cost_value;
      logic [HIT_W-1:0]  hit_count;
      logic              updated;
   } rsp_item_type;

endpackage

>>> hdl/cost_volume_accumulate.sv
// ----------------------------------------------------------------------------
// Cost volume accumulate
// Read-modify-write update of per-cell photometric cost and hit count.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low. It
// names one cell (pixel and depth layer) and carries a valid flag and three
// warped and three reference channels. Each item yields one result on
// rsp_item, marked by rsp_strobe for one cycle, in the order the items were
// taken.
// Items enter one per cycle while busy is low. The cell store is a single
// memory read at the accepting edge and written back when the item leaves
// the 24-stage divider that forms the running mean. busy stays high while
// the addressed cell is still in flight for an update, so an item that hits
// the same cell as an earlier updating item waits until that one is written
// back.
// After reset the memory is cleared one cell per cycle, all PIXELS*LAYERS
// cells, and busy is high until the pass ends. The user must write registers
// on the APB port only while no item is in flight; the block does not check.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module cost_volume_accumulate #(
   parameter int PIXELS = 1024,
   parameter int LAYERS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  cva_pkg::req_item_type             req_item,
   output logic                              rsp_strobe,
   output cva_pkg::rsp_item_type             rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cva_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [cva_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cva_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   import cva_pkg::*;

   localparam int CELLS = PIXELS * LAYERS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int HZ_N  = DIV_STAGES + 3;
   localparam int LAT   = DIV_STAGES + 4;
   localparam int TAG_W = 2 + AW + COST_W + HIT_W;
   localparam logic [31:0]   PIXELS_U = 32'(PIXELS);
   localparam logic [31:0]   LAYERS_U = 32'(LAYERS);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

   logic norm_mode_ff;
   logic single_channel_ff;
   logic csr_wr;

   logic          clear_ff;
   logic [AW-1:0] clr_addr_ff;

   logic          accept;
   logic          in_range;
   logic [AW-1:0] req_cell;
   logic          hazard;

   logic          hz_vld_ff  [HZ_N];
   logic [AW-1:0] hz_addr_ff [HZ_N];

   logic [DIVD_W-1:0] rd_data;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DIVD_W-1:0] wr_data;

   logic          s1_act_ff;
   req_item_type  s1_item_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          s1_range_ff;

   logic [COST_W-1:0] cost_rd;
   logic [HIT_W-1:0]  hit_rd;
   logic [CH_W-1:0]   d0;
   logic [CH_W-1:0]   d1;
   logic [CH_W-1:0]   d2;
   logic [HIT_W-1:0]  h_in;
   logic [HIT_W-1:0]  hm1;
   logic [17:0]       sum_in;
   logic [DIVD_W-1:0] prod_in;
   logic [31:0]       sq0_in;
   logic [31:0]       sq1_in;
   logic [31:0]       sq2_in;

   logic              s2_act_ff;
   logic [DIVD_W-1:0] s2_prod_ff;
   logic [17:0]       s2_sum_ff;
   logic [31:0]       s2_sq0_ff;
   logic [31:0]       s2_sq1_ff;
   logic [31:0]       s2_sq2_ff;
   logic [COST_W-1:0] s2_cost_ff;
   logic [HIT_W-1:0]  s2_hit_ff;
   logic [HIT_W-1:0]  s2_h_ff;
   logic [AW-1:0]     s2_addr_ff;
   logic              s2_range_ff;
   logic              s2_valid_ff;

   logic              s2_upd;
   logic              s2_use_q;
   logic [COST_W+1:0] l2_acc;
   logic [COST_W-1:0] l2_cost;
   logic [COST_W-1:0] alt_cost;
   logic [HIT_W-1:0]  hit_out;
   logic [DIVD_W-1:0] dividend;

   logic              div_vld;
   logic [COST_W-1:0] div_quot;
   logic [TAG_W-1:0]  div_tag;
   logic              t_upd;
   logic              t_use_q;
   logic [AW-1:0]     t_addr;
   logic [COST_W-1:0] t_cost;
   logic [HIT_W-1:0]  t_hit;
   logic [COST_W-1:0] cost_fin;

   logic         rsp_strobe_ff;
   rsp_item_type rsp_item_ff;

   // Configuration port
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_mode_ff      <= 1'b0;
         single_channel_ff <= 1'b0;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_NORM_MODE:      norm_mode_ff      <= pwdata[0];
            REG_SINGLE_CHANNEL: single_channel_ff <= pwdata[0];
            default:            norm_mode_ff      <= norm_mode_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_NORM_MODE:      prdata = {{(CSR_DATA_W-1){1'b0}}, norm_mode_ff};
         REG_SINGLE_CHANNEL: prdata = {{(CSR_DATA_W-1){1'b0}}, single_channel_ff};
         default:            prdata = '0;
      endcase
   end

   // Clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_CELL) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // Intake and same-cell interlock
   assign in_range = ({22'd0, req_item.pixel_index} < PIXELS_U) &&
                     ({27'd0, req_item.layer} < LAYERS_U);
   assign req_cell = AW'({22'd0, req_item.pixel_index} * LAYERS_U +
                         {27'd0, req_item.layer});

   always_comb begin
      hazard = 1'b0;
      for (int k = 0; k < HZ_N; k++) begin
         if (hz_vld_ff[k] && (hz_addr_ff[k] == req_cell)) begin
            hazard = 1'b1;
         end
      end
   end

   assign busy   = clear_ff | (in_range & hazard);
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HZ_N; k++) begin
            hz_vld_ff[k] <= 1'b0;
         end
      end else begin
         hz_vld_ff[0] <= accept & in_range & req_item.valid_req;
         for (int k = 1; k < HZ_N; k++) begin
            hz_vld_ff[k] <= hz_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      hz_addr_ff[0] <= req_cell;
      for (int k = 1; k < HZ_N; k++) begin
         hz_addr_ff[k] <= hz_addr_ff[k-1];
      end
   end

   cva_mem #(
      .DEPTH (CELLS),
      .AW    (AW),
      .DW    (DIVD_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (accept & in_range),
      .rd_addr (req_cell),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Stage 1: differences and products
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_act_ff <= 1'b0;
      end else begin
         s1_act_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= req_item;
      s1_addr_ff  <= req_cell;
      s1_range_ff <= in_range;
   end

   function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   assign cost_rd = rd_data[DIVD_W-1:HIT_W];
   assign hit_rd  = rd_data[HIT_W-1:0];
   assign d0      = abs_diff(s1_item_ff.warped_c0, s1_item_ff.ref_c0);
   assign d1      = abs_diff(s1_item_ff.warped_c1, s1_item_ff.ref_c1);
   assign d2      = abs_diff(s1_item_ff.warped_c2, s1_item_ff.ref_c2);
   assign h_in    = (hit_rd == HIT_MAX) ? HIT_MAX : hit_rd + 1'b1;
   assign hm1     = h_in - 1'b1;
   assign sum_in  = {2'd0, d0} + {2'd0, d1} + {2'd0, d2};
   assign prod_in = {{HIT_W{1'b0}}, cost_rd} * {{COST_W{1'b0}}, hm1};
   assign sq0_in  = d0 * d0;
   assign sq1_in  = d1 * d1;
   assign sq2_in  = d2 * d2;

   // Stage 2: accumulate and prepare the division
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_act_ff <= 1'b0;
      end else begin
         s2_act_ff <= s1_act_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_prod_ff  <= prod_in;
      s2_sum_ff   <= sum_in;
      s2_sq0_ff   <= sq0_in;
      s2_sq1_ff   <= sq1_in;
      s2_sq2_ff   <= sq2_in;
      s2_cost_ff  <= cost_rd;
      s2_hit_ff   <= hit_rd;
      s2_h_ff     <= h_in;
      s2_addr_ff  <= s1_addr_ff;
      s2_range_ff <= s1_range_ff;
      s2_valid_ff <= s1_item_ff.valid_req;
   end

   assign s2_upd   = s2_range_ff & s2_valid_ff;
   assign s2_use_q = s2_upd & ~norm_mode_ff;

   always_comb begin
      l2_acc = {2'd0, s2_cost_ff} + {18'd0, s2_sq0_ff};
      if (!single_channel_ff) begin
         l2_acc = l2_acc + {18'd0, s2_sq1_ff} + {18'd0, s2_sq2_ff};
      end
   end

   assign l2_cost  = (l2_acc > {2'd0, COST_MAX}) ? COST_MAX : l2_acc[COST_W-1:0];
   assign alt_cost = !s2_range_ff ? '0 : (!s2_valid_ff ? s2_cost_ff : l2_cost);
   assign hit_out  = !s2_range_ff ? '0 : (!s2_valid_ff ? s2_hit_ff : s2_h_ff);
   assign dividend = s2_use_q ? (s2_prod_ff + {38'd0, s2_sum_ff, 8'd0}) : '0;

   cva_div #(
      .TAG_W (TAG_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_vld      (s2_act_ff),
      .in_dividend (dividend),
      .in_divisor  (s2_h_ff),
      .in_tag      ({s2_upd, s2_use_q, s2_addr_ff, alt_cost, hit_out}),
      .out_vld     (div_vld),
      .out_quot    (div_quot),
      .out_tag     (div_tag)
   );

   // Write back and result
   assign {t_upd, t_use_q, t_addr, t_cost, t_hit} = div_tag;
   assign cost_fin = t_use_q ? div_quot : t_cost;

   assign wr_en   = clear_ff | (div_vld & t_upd);
   assign wr_addr = clear_ff ? clr_addr_ff : t_addr;
   assign wr_data = clear_ff ? '0 : {cost_fin, t_hit};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff.cost_value <= cost_fin;
      rsp_item_ff.hit_count  <= t_hit;
      rsp_item_ff.updated    <= t_upd;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // Checks
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("result did not follow its item at the fixed latency");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !div_vld)
      else $error("item write-back during the clearing pass");

   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.updated) |-> (rsp_item.hit_count != '0))
      else $error("updated cell reports a zero hit count");

endmodule

>>> hdl/cva_mem.sv
// ----------------------------------------------------------------------------
// Cost volume cell memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module cva_mem #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15,
   parameter int DW    = 64
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cva_div.sv
// ----------------------------------------------------------------------------
// Cost volume pipelined divider
// Restoring division of a 64-bit dividend by a 16-bit divisor, two quotient
// bits per stage, with a tag carried alongside each item.
// ----------------------------------------------------------------------------
module cva_div #(
   parameter int TAG_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_vld,
   input  logic [cva_pkg::DIVD_W-1:0]  in_dividend,
   input  logic [cva_pkg::HIT_W-1:0]   in_divisor,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_vld,
   output logic [cva_pkg::COST_W-1:0]  out_quot,
   output logic [TAG_W-1:0]            out_tag
);

   import cva_pkg::*;

   logic [DIV_STAGES:0] vld_ff;
   logic [DIVD_W-1:0]   work_ff [DIV_STAGES+1];
   logic [DIVD_W-1:0]   work_in [DIV_STAGES+1];
   logic [HIT_W-1:0]    dsr_ff  [DIV_STAGES+1];
   logic [TAG_W-1:0]    tag_ff  [DIV_STAGES+1];

   // The upper part holds the partial remainder, the lower part the dividend
   // bits still to come, which are replaced by quotient bits.
   function automatic logic [DIVD_W-1:0] div_step(input logic [DIVD_W-1:0] w,
                                                  input logic [HIT_W-1:0]  d);
      logic [HIT_W:0]    r;
      logic [HIT_W:0]    diff;
      logic [DIVD_W-1:0] res;
      r    = {w[DIVD_W-1 -: HIT_W], w[COST_W-1]};
      diff = r - {1'b0, d};
      if (r >= {1'b0, d}) begin
         res = {diff[HIT_W-1:0], w[COST_W-2:0], 1'b1};
      end else begin
         res = {r[HIT_W-1:0], w[COST_W-2:0], 1'b0};
      end
      return res;
   endfunction

   always_comb begin
      work_in[0] = in_dividend;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         work_in[k] = work_ff[k-1];
         for (int b = 0; b < DIV_BITS; b++) begin
            work_in[k] = div_step(work_in[k], dsr_ff[k-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIV_STAGES-1:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      work_ff[0] <= work_in[0];
      dsr_ff[0]  <= in_divisor;
      tag_ff[0]  <= in_tag;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         work_ff[k] <= work_in[k];
         dsr_ff[k]  <= dsr_ff[k-1];
         tag_ff[k]  <= tag_ff[k-1];
      end
   end

   assign out_vld  = vld_ff[DIV_STAGES];
   assign out_quot = work_ff[DIV_STAGES][COST_W-1:0];
   assign out_tag  = tag_ff[DIV_STAGES];

endmodule

>>> bench/cost_volume_accumulate_tb.sv
// ----------------------------------------------------------------------------
// Cost volume accumulate testbench
// Drives cost volume cells through the command port and the APB registers in
// mean and squared modes. Each result is checked field by field against a
// predictor that keeps its own copy of the cost and hit stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cost_volume_accumulate_tb;
   import cva_pkg::*;

   localparam int CELLS = 1024 * 32;
   localparam int DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [CSR_ADDR_W-1:0] ADDR_NORM_MODE = {REG_NORM_MODE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SINGLE_CHANNEL = {REG_SINGLE_CHANNEL, 2'b00};

   class cell_cost_board;
      logic [COST_W-1:0] cost_mem [CELLS];
      logic [HIT_W-1:0]  hit_mem [CELLS];
      logic              squared_mode;
      logic              one_channel;
      rsp_item_type      expected_q[$];
      int                errors;
      int                checked;

      function new();
         foreach (cost_mem[i]) begin
            cost_mem[i] = '0;
            hit_mem[i] = '0;
         end
         squared_mode = 1'b0;
         one_channel = 1'b0;
         errors = 0;
         checked = 0;
      endfunction

      function logic [63:0] abs_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
         return (a > b) ? 64'(a - b) : 64'(b - a);
      endfunction

      function void note_item(req_item_type r);
         int unsigned  cell_idx;
         logic [63:0]  d0, d1, d2, h, acc;
         rsp_item_type e;
         cell_idx = 32'({r.pixel_index, r.layer});
         if (!r.valid_req) begin
            e.cost_value = cost_mem[cell_idx];
            e.hit_count = hit_mem[cell_idx];
            e.updated = 1'b0;
         end else begin
            d0 = abs_diff(r.warped_c0, r.ref_c0);
            d1 = abs_diff(r.warped_c1, r.ref_c1);
            d2 = abs_diff(r.warped_c2, r.ref_c2);
            h = (hit_mem[cell_idx] < HIT_MAX) ? 64'(hit_mem[cell_idx]) + 1 : 64'(HIT_MAX);
            if (!squared_mode) begin
               acc = (64'(cost_mem[cell_idx]) * (h - 1) + ((d0 + d1 + d2) << 8)) / h;
            end else begin
               acc = 64'(cost_mem[cell_idx]) + d0 * d0;
               if (!one_channel) acc = acc + d1 * d1 + d2 * d2;
               if (acc > 64'(COST_MAX)) acc = 64'(COST_MAX);
            end
            cost_mem[cell_idx] = acc[COST_W-1:0];
            hit_mem[cell_idx] = h[HIT_W-1:0];
            e.cost_value = acc[COST_W-1:0];
            e.hit_count = h[HIT_W-1:0];
            e.updated = 1'b1;
         end
         expected_q.push_back(e);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected: %p", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (got.cost_value !== e.cost_value) begin
            $display("%0t: cost_value expected %0d actual %0d", $time, e.cost_value,
                     got.cost_value);
            errors++;
         end
         if (got.hit_count !== e.hit_count) begin
            $display("%0t: hit_count expected %0d actual %0d", $time, e.hit_count,
                     got.hit_count);
            errors++;
         end
         if (got.updated !== e.updated) begin
            $display("%0t: updated expected %0b actual %0b", $time, e.updated,
                     got.updated);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_item_type          req_item;
   logic                  rsp_strobe;
   rsp_item_type          rsp_item;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cell_cost_board board;
   longint         cycles;
   int             items_sent;
   int             phases_run;
   bit             no_gaps;
   logic [9:0]     hot_pixel [8];
   logic [4:0]     hot_layer [8];

   cost_volume_accumulate dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("cost_volume_accumulate_tb: done, errors");
         $finish;
      end
      if (!reset && rsp_strobe) board.check_result(rsp_item);
      if (!reset && start && !busy) board.note_item(req_item);
   end

   task automatic idle_gap();
      int n;
      n = 0;
      if (!no_gaps) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: n = $urandom_range(1, 3);
            5: n = $urandom_range(15, 60);
            default: n = 0;
         endcase
      end
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_item(req_item_type r);
      idle_gap();
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_NORM_MODE) board.squared_mode = data[0];
      else board.one_channel = data[0];
      @(posedge clock);
   endtask

   task automatic set_modes(logic squared, logic single);
      write_reg(ADDR_NORM_MODE, {16'($urandom_range(0, 65535)), 15'd0, squared});
      write_reg(ADDR_SINGLE_CHANNEL, {16'($urandom_range(0, 65535)), 15'd0, single});
   endtask

   function automatic logic [CH_W-1:0] rand_channel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return CH_W'($urandom);
      endcase
   endfunction

   function automatic req_item_type rand_item();
      req_item_type r;
      int k;
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 9) < 7) begin
         r.pixel_index = hot_pixel[k];
         r.layer = hot_layer[k];
      end else begin
         r.pixel_index = 10'($urandom);
         r.layer = 5'($urandom);
      end
      r.valid_req = ($urandom_range(0, 9) != 0);
      r.warped_c0 = rand_channel();
      r.warped_c1 = rand_channel();
      r.warped_c2 = rand_channel();
      r.ref_c0 = rand_channel();
      r.ref_c1 = rand_channel();
      r.ref_c2 = rand_channel();
      return r;
   endfunction

   task automatic directed_items();
      req_item_type r;
      r = '{pixel_index: 10'd0, layer: 5'd0, valid_req: 1'b1,
            warped_c0: '0, warped_c1: '0, warped_c2: '0,
            ref_c0: '0, ref_c1: '0, ref_c2: '0};
      send_item(r);
      r.warped_c0 = '1; r.warped_c1 = '1; r.warped_c2 = '1;
      send_item(r);
      send_item(r);
      r.pixel_index = 10'd1023; r.layer = 5'd31;
      r.warped_c0 = '0; r.warped_c1 = '0; r.warped_c2 = '0;
      r.ref_c0 = '1; r.ref_c1 = '1; r.ref_c2 = '1;
      send_item(r);
      r.valid_req = 1'b0;
      send_item(r);
      r.pixel_index = 10'h2AA; r.layer = 5'h15; r.valid_req = 1'b1;
      r.warped_c0 = 16'hAAAA; r.ref_c0 = 16'h5555;
      r.warped_c1 = 16'h5555; r.ref_c1 = 16'hAAAA;
      r.warped_c2 = 16'h0001; r.ref_c2 = 16'h0000;
      send_item(r);
      r.pixel_index = 10'h155; r.layer = 5'h0A;
      send_item(r);
      r.valid_req = 1'b0;
      send_item(r);
      r.pixel_index = 10'd0; r.layer = 5'd0;
      send_item(r);
   endtask

   task automatic run_phase(logic squared, logic single, int count);
      set_modes(squared, single);
      no_gaps = 1'b0;
      directed_items();
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         send_item(rand_item());
      end
      wait_idle();
      phases_run++;
   endtask

   initial begin
      board = new();
      cycles = 0;
      items_sent = 0;
      phases_run = 0;
      no_gaps = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      foreach (hot_pixel[i]) begin
         hot_pixel[i] = 10'($urandom);
         hot_layer[i] = 5'($urandom);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_phase(1'b0, 1'b0, 300);
      run_phase(1'b1, 1'b0, 300);
      run_phase(1'b1, 1'b1, 300);
      run_phase(1'b0, 1'b1, 300);
      run_phase(1'b1, 1'b0, 300);
      $display("Sent %0d items over %0d register settings, %0d results checked.",
               items_sent, phases_run, board.checked);
      $display("Both modes, one and three channels, invalid items and mode changes on "
               , "filled cells were covered.");
      if (board.errors == 0 && board.expected_q.size() == 0)
         $display("cost_volume_accumulate_tb: done, clean");
      else
         $display("cost_volume_accumulate_tb: done, errors");
      $finish;
   end

endmodule
